FILE: rtl/core/pin_interrupt_debounce_dispatch_top_macros.svh
// assertion macros shared by the checker
`ifndef PIN_INTERRUPT_DEBOUNCE_DISPATCH_TOP_MACROS_SVH
`define PIN_INTERRUPT_DEBOUNCE_DISPATCH_TOP_MACROS_SVH

// clocked check, off while reset is high
`define PIDD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds through reset
`define PIDD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/pidd_pkg.sv
package pidd_pkg;

   localparam int NUM_PORTS         = 4;
   localparam int PINS_PER_PORT     = 32;
   localparam int TOTAL_PINS        = NUM_PORTS * PINS_PER_PORT;
   localparam int PIN_IDX_BITS      = $clog2(TOTAL_PINS);
   localparam int PORT_BIT_BITS     = $clog2(PINS_PER_PORT);
   localparam int TIME_BITS         = 48;
   localparam int EVENT_PIN_BITS    = 7;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);
   localparam logic [31:0] DEFAULT_THRESHOLD = 32'd200000;

   localparam logic [1:0] OP_SET_THRESHOLD = 2'd0;
   localparam logic [1:0] OP_ARM           = 2'd1;
   localparam logic [1:0] OP_SERVICE       = 2'd2;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_THRESH,
      KIND_ARM,
      KIND_DISARM,
      KIND_SERVICE
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      kind_type                 kind;
      logic [PIN_IDX_BITS-1:0]  idx;
      logic [31:0]              ticks;
      logic [1:0]               port;
      logic [31:0]              pending;
      logic [31:0]              level;
      logic [TIME_BITS-1:0]     now;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic                     found;
      logic [PORT_BIT_BITS-1:0] bit_idx;
   } scan_hit_type;

   // priority encoder, lowest set bit wins
   function automatic scan_hit_type lowest_set(input logic [PINS_PER_PORT-1:0] v);
      scan_hit_type hit;
      hit.found   = 1'b0;
      hit.bit_idx = '0;
      for (int i = PINS_PER_PORT - 1; i >= 0; i--) begin
         if (v[i]) begin
            hit.found   = 1'b1;
            hit.bit_idx = PORT_BIT_BITS'(i);
         end
      end
      return hit;
   endfunction

endpackage

FILE: rtl/core/pidd_front.sv
module pidd_front
   import pidd_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [6:0]           req_pin,
   input  logic [31:0]          req_debounce_ticks,
   input  logic                 req_enable,
   input  logic [1:0]           req_port,
   input  logic [31:0]          req_pending_bits,
   input  logic [31:0]          req_level_bits,
   input  logic [TIME_BITS-1:0] req_now,
   input  q_stat_type           q_stat,
   output logic                 q_push,
   output q_entry_type          q_entry
);

   logic pin_ok;
   logic port_ok;

   assign pin_ok    = 9'(req_pin) < 9'(TOTAL_PINS);
   assign port_ok   = 4'(req_port) < 4'(NUM_PORTS);
   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      q_entry.kind    = KIND_NOP;
      q_entry.idx     = PIN_IDX_BITS'(req_pin);
      q_entry.ticks   = req_debounce_ticks;
      q_entry.port    = req_port;
      q_entry.pending = req_pending_bits;
      q_entry.level   = req_level_bits;
      q_entry.now     = req_now;
      case (req_operation)
         OP_SET_THRESHOLD: begin
            if (pin_ok) q_entry.kind = KIND_THRESH;
         end
         OP_ARM: begin
            if (pin_ok) q_entry.kind = req_enable ? KIND_ARM : KIND_DISARM;
         end
         OP_SERVICE: begin
            // base index of the port's first pin
            q_entry.idx = PIN_IDX_BITS'({req_port, {PORT_BIT_BITS{1'b0}}});
            if (port_ok) q_entry.kind = KIND_SERVICE;
         end
         default: begin
            q_entry.kind = KIND_NOP;
         end
      endcase
   end

endmodule

FILE: rtl/core/pidd_queue.sv
module pidd_queue
   import pidd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_push,
   input  q_entry_type q_entry,
   input  logic        q_pop,
   output q_entry_type q_head,
   output q_stat_type  q_stat
);

   q_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign q_stat.full  = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign q_head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (q_pop && !q_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) entries_ff[wr_ptr_ff] <= q_entry;
   end

endmodule

FILE: rtl/core/pidd_back.sv
module pidd_back
   import pidd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  q_stat_type                q_stat,
   input  q_entry_type               q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_has_event,
   output logic [EVENT_PIN_BITS-1:0] rsp_event_pin,
   output logic                      rsp_rising_edge,
   output logic                      rsp_last
);

   back_state_type state_ff, state_in;

   logic [1:0]                port_ff, port_in;
   logic [PIN_IDX_BITS-1:0]   base_ff, base_in;
   logic [PINS_PER_PORT-1:0]  scan_ff, scan_in;
   logic [PINS_PER_PORT-1:0]  level_ff, level_in;
   logic [TIME_BITS-1:0]      now_ff, now_in;
   logic [PORT_BIT_BITS-1:0]  cur_bit_ff, cur_bit_in;
   logic                      held_valid_ff, held_valid_in;
   logic [EVENT_PIN_BITS-1:0] held_pin_ff, held_pin_in;
   logic                      held_rise_ff, held_rise_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_has_event_ff, rsp_has_event_in;
   logic [EVENT_PIN_BITS-1:0] rsp_event_pin_ff, rsp_event_pin_in;
   logic                      rsp_rising_ff, rsp_rising_in;
   logic                      rsp_last_ff, rsp_last_in;

   // per-pin flags in flops; thr_valid marks thresholds written since reset
   logic [TOTAL_PINS-1:0]     irq_en_ff, irq_en_in;
   logic [TOTAL_PINS-1:0]     armed_ff, armed_in;
   logic [TOTAL_PINS-1:0]     thr_nz_ff, thr_nz_in;
   logic [TOTAL_PINS-1:0]     thr_valid_ff, thr_valid_in;

   logic [31:0]               thr_mem_ff  [TOTAL_PINS];
   logic [TIME_BITS-1:0]      fire_mem_ff [TOTAL_PINS];
   logic [31:0]               thr_rd_ff;
   logic [TIME_BITS-1:0]      fire_rd_ff;

   logic                      thr_we;
   logic                      fire_we;
   logic [PIN_IDX_BITS-1:0]   wr_idx;
   logic [TIME_BITS-1:0]      fire_wdata;
   logic                      rd_en;
   logic [PIN_IDX_BITS-1:0]   rd_idx;

   logic [PINS_PER_PORT-1:0]  en_slice;
   scan_hit_type              hit;
   logic [PIN_IDX_BITS-1:0]   cur_idx;
   logic [31:0]               thr_eff;
   logic [TIME_BITS-1:0]      elapsed;
   logic                      fire;
   logic                      out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_event   = rsp_has_event_ff;
   assign rsp_event_pin   = rsp_event_pin_ff;
   assign rsp_rising_edge = rsp_rising_ff;
   assign rsp_last        = rsp_last_ff;

   assign en_slice = irq_en_ff[base_ff +: PINS_PER_PORT];
   assign hit      = lowest_set(scan_ff & en_slice);
   assign cur_idx  = base_ff | PIN_IDX_BITS'(cur_bit_ff);
   assign thr_eff  = thr_valid_ff[cur_idx] ? thr_rd_ff : DEFAULT_THRESHOLD;
   assign elapsed  = now_ff - fire_rd_ff;
   assign fire     = !armed_ff[cur_idx] || (elapsed >= TIME_BITS'(thr_eff));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      port_in          = port_ff;
      base_in          = base_ff;
      scan_in          = scan_ff;
      level_in         = level_ff;
      now_in           = now_ff;
      cur_bit_in       = cur_bit_ff;
      held_valid_in    = held_valid_ff;
      held_pin_in      = held_pin_ff;
      held_rise_in     = held_rise_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_has_event_in = rsp_has_event_ff;
      rsp_event_pin_in = rsp_event_pin_ff;
      rsp_rising_in    = rsp_rising_ff;
      rsp_last_in      = rsp_last_ff;
      irq_en_in        = irq_en_ff;
      armed_in         = armed_ff;
      thr_nz_in        = thr_nz_ff;
      thr_valid_in     = thr_valid_ff;
      q_pop            = 1'b0;
      thr_we           = 1'b0;
      fire_we          = 1'b0;
      wr_idx           = q_head.idx;
      fire_wdata       = q_head.now;
      rd_en            = 1'b0;
      rd_idx           = base_ff | PIN_IDX_BITS'(hit.bit_idx);

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               port_in  = q_head.port;
               base_in  = q_head.idx;
               scan_in  = q_head.pending;
               level_in = q_head.level;
               now_in   = q_head.now;
               state_in = ST_FINISH;
               case (q_head.kind)
                  KIND_THRESH: begin
                     thr_we                   = 1'b1;
                     thr_nz_in[q_head.idx]    = q_head.ticks != '0;
                     thr_valid_in[q_head.idx] = 1'b1;
                  end
                  KIND_ARM: begin
                     fire_we               = 1'b1;
                     armed_in[q_head.idx]  = thr_nz_ff[q_head.idx];
                     irq_en_in[q_head.idx] = 1'b1;
                  end
                  KIND_DISARM: begin
                     irq_en_in[q_head.idx] = 1'b0;
                  end
                  KIND_SERVICE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit.found) begin
               rd_en      = 1'b1;
               cur_bit_in = hit.bit_idx;
               scan_in    = scan_ff & ~(PINS_PER_PORT'(1) << hit.bit_idx);
               state_in   = ST_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CHECK: begin
            // a new event pushes the held one out, so wait for a free output
            if (!(fire && held_valid_ff && !out_free)) begin
               if (fire) begin
                  if (armed_ff[cur_idx]) begin
                     fire_we    = 1'b1;
                     wr_idx     = cur_idx;
                     fire_wdata = now_ff;
                  end
                  if (held_valid_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_has_event_in = 1'b1;
                     rsp_event_pin_in = held_pin_ff;
                     rsp_rising_in    = held_rise_ff;
                     rsp_last_in      = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_pin_in   = {port_ff, cur_bit_ff};
                  held_rise_in  = level_ff[cur_bit_ff];
               end
               if (hit.found) begin
                  rd_en      = 1'b1;
                  cur_bit_in = hit.bit_idx;
                  scan_in    = scan_ff & ~(PINS_PER_PORT'(1) << hit.bit_idx);
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_event_in = held_valid_ff;
               rsp_event_pin_in = held_valid_ff ? held_pin_ff : '0;
               rsp_rising_in    = held_valid_ff && held_rise_ff;
               rsp_last_in      = 1'b1;
               held_valid_in    = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         irq_en_ff     <= '0;
         armed_ff      <= '0;
         thr_nz_ff     <= '1;
         thr_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         irq_en_ff     <= irq_en_in;
         armed_ff      <= armed_in;
         thr_nz_ff     <= thr_nz_in;
         thr_valid_ff  <= thr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff          <= port_in;
      base_ff          <= base_in;
      scan_ff          <= scan_in;
      level_ff         <= level_in;
      now_ff           <= now_in;
      cur_bit_ff       <= cur_bit_in;
      held_pin_ff      <= held_pin_in;
      held_rise_ff     <= held_rise_in;
      rsp_has_event_ff <= rsp_has_event_in;
      rsp_event_pin_ff <= rsp_event_pin_in;
      rsp_rising_ff    <= rsp_rising_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (thr_we) thr_mem_ff[wr_idx] <= q_head.ticks;
      if (fire_we) fire_mem_ff[wr_idx] <= fire_wdata;
      if (rd_en) begin
         thr_rd_ff  <= thr_mem_ff[rd_idx];
         fire_rd_ff <= fire_mem_ff[rd_idx];
      end
   end

endmodule

FILE: rtl/core/pin_interrupt_debounce_dispatch_top.sv
// channel  dir  handshake           payload
// req      in   req_valid/req_stall operation, pin, debounce_ticks, enable, port,
//                                   pending_bits, level_bits, now
// rsp      out  rsp_valid/rsp_stall has_event, event_pin, rising_edge, last
//
// a 2-entry queue sits between the classifier and the table engine
// threshold writes, arm and disarm go from idle straight to the finish state in the engine
// a port service runs idle, scan, one check per pending enabled pin (up to 32) and finish,
// with one threshold/fire-time table read per pin
// reset is synchronous; flags take their reset values at once, no clearing pass
// rsp_stall holds the output register and the engine when it has a result to give; requests queue up behind it
module pin_interrupt_debounce_dispatch_top
   import pidd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [6:0]                req_pin,
   input  logic [31:0]               req_debounce_ticks,
   input  logic                      req_enable,
   input  logic [1:0]                req_port,
   input  logic [31:0]               req_pending_bits,
   input  logic [31:0]               req_level_bits,
   input  logic [TIME_BITS-1:0]      req_now,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_has_event,
   output logic [EVENT_PIN_BITS-1:0] rsp_event_pin,
   output logic                      rsp_rising_edge,
   output logic                      rsp_last
);

   q_stat_type  q_stat;
   q_entry_type q_entry;
   q_entry_type q_head;
   logic        q_push;
   logic        q_pop;

   pidd_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_pin            (req_pin),
      .req_debounce_ticks (req_debounce_ticks),
      .req_enable         (req_enable),
      .req_port           (req_port),
      .req_pending_bits   (req_pending_bits),
      .req_level_bits     (req_level_bits),
      .req_now            (req_now),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_entry            (q_entry)
   );

   pidd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_stat  (q_stat)
   );

   pidd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_event   (rsp_has_event),
      .rsp_event_pin   (rsp_event_pin),
      .rsp_rising_edge (rsp_rising_edge),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: rtl/core/pidd_checker.sv
`include "pin_interrupt_debounce_dispatch_top_macros.svh"

module pidd_checker
   import pidd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_has_event,
   input logic [EVENT_PIN_BITS-1:0] rsp_event_pin,
   input logic                      rsp_rising_edge,
   input logic                      rsp_last
);

   // protocol: a stalled item stays and holds its payload
   `PIDD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "rsp item dropped while stalled")
   `PIDD_ASSERT(a_rsp_stable,
      rsp_valid && rsp_stall |=> $stable(rsp_has_event) && $stable(rsp_event_pin)
         && $stable(rsp_rising_edge) && $stable(rsp_last),
      "rsp payload changed while stalled")

   // an item without events gives exactly one blank, final result
   `PIDD_ASSERT(a_blank_shape,
      rsp_valid && !rsp_has_event |-> rsp_last && rsp_event_pin == '0 && !rsp_rising_edge,
      "blank result not final or not zero")

   // a taken non-final event is not directly followed by a blank result
   `PIDD_ASSERT(a_no_blank_mid,
      rsp_valid && !rsp_stall && rsp_has_event && !rsp_last |=> !(rsp_valid && !rsp_has_event),
      "blank result inside an event run")

   // output register is empty right after reset
   `PIDD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind pin_interrupt_debounce_dispatch_top pidd_checker u_pidd_checker (.*);
